// ===== src/pdll_pkg.sv =====
// shared types, sizes and codes of the pooled doubly linked list
package pdll_pkg;

   localparam int POOL_SIZE  = 64;
   localparam int SLOT_W     = 6;
   localparam int VALUE_W    = 16;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int WORD_W     = 8;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int WORD_N     = POOL_SIZE / WORD_W;
   localparam int WORD_IDX_W = SLOT_W - BIT_W;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_UNALLOC = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [SLOT_W-1:0]        node_index;
      logic signed [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [SLOT_W-1:0]         slot_used;
      logic signed [VALUE_W-1:0] read_value;
      logic [SLOT_W-1:0]         next_index;
      logic [SLOT_W-1:0]         prev_index;
   } rsp_type;

   // control from the sequencer to the allocation flags
   typedef struct packed {
      logic              start;
      logic              set_en;
      logic              clr_en;
      logic [SLOT_W-1:0] slot;
   } used_ctrl_type;

   // outcome of the free slot scan
   typedef struct packed {
      logic              done;
      logic              found;
      logic [SLOT_W-1:0] slot;
   } scan_res_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOOK   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_LINK_A = 6'b001000,
      S_LINK_B = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

endpackage

// ===== src/pdll_free_scan.sv =====
// allocation flags of the node pool and the word-serial lowest free slot scan
module pdll_free_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  pdll_pkg::used_ctrl_type       ctrl,
   input  logic [pdll_pkg::SLOT_W-1:0]   query_slot,
   output logic                          query_used,
   output pdll_pkg::scan_res_type        scan_res
);

   localparam logic [pdll_pkg::WORD_IDX_W-1:0] LAST_WORD =
      pdll_pkg::WORD_IDX_W'(pdll_pkg::WORD_N - 1);

   logic [pdll_pkg::WORD_N-1:0][pdll_pkg::WORD_W-1:0] used_ff, used_in;
   logic [pdll_pkg::WORD_IDX_W-1:0] word_ff, word_in;
   logic                            active_ff, active_in;
   logic [pdll_pkg::WORD_W-1:0]     word_bits;
   logic                            any_free;

   // lowest clear bit of one flag word
   function automatic logic [pdll_pkg::BIT_W-1:0] first_zero(
      input logic [pdll_pkg::WORD_W-1:0] w);
      logic [pdll_pkg::BIT_W-1:0] pos;
      pos = '0;
      for (int i = pdll_pkg::WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            pos = pdll_pkg::BIT_W'(i);
         end
      end
      return pos;
   endfunction

   assign word_bits  = used_ff[word_ff];
   assign any_free   = ~&word_bits;
   assign query_used = used_ff[query_slot[pdll_pkg::SLOT_W-1:pdll_pkg::BIT_W]]
                              [query_slot[pdll_pkg::BIT_W-1:0]];

   assign scan_res.done  = active_ff && (any_free || (word_ff == LAST_WORD));
   assign scan_res.found = active_ff && any_free;
   assign scan_res.slot  = {word_ff, first_zero(word_bits)};

   always_comb begin
      used_in   = used_ff;
      word_in   = word_ff;
      active_in = active_ff;
      if (ctrl.set_en) begin
         used_in[ctrl.slot[pdll_pkg::SLOT_W-1:pdll_pkg::BIT_W]]
                [ctrl.slot[pdll_pkg::BIT_W-1:0]] = 1'b1;
      end
      if (ctrl.clr_en) begin
         used_in[ctrl.slot[pdll_pkg::SLOT_W-1:pdll_pkg::BIT_W]]
                [ctrl.slot[pdll_pkg::BIT_W-1:0]] = 1'b0;
      end
      priority if (ctrl.start) begin
         active_in = 1'b1;
         word_in   = '0;
      end else if (scan_res.done) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         word_in = word_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // only the head slot starts allocated
         used_ff   <= {{(pdll_pkg::POOL_SIZE-1){1'b0}}, 1'b1};
         word_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         word_ff   <= word_in;
         active_ff <= active_in;
      end
   end

endmodule

// ===== src/pooled_doubly_linked_list_top.sv =====
// top level of the pooled circular doubly linked list with its sequencer
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  req     | in        | req_valid / req_stall | req_data: operation, node_index, value
//  rsp     | out       | rsp_valid / rsp_stall | rsp_data: status, slot, value, links
//
// one request at a time; req_stall is low only while the sequencer is idle
// read, delete, unknown operations and insert on a bad anchor: lookup, then done
// insert: lookup, scan of 1-8 flag words, links A and B, done; full pool skips the links
// reset: sequencer, allocation flags and head links reset at once, no clearing pass
// a result waits in the output register; a stalled rsp holds the sequencer in its last step
module pooled_doubly_linked_list_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pdll_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pdll_pkg::rsp_type rsp_data
);

   // link and value memories, one write and one registered read each
   logic [pdll_pkg::SLOT_W-1:0]         next_ram  [pdll_pkg::POOL_SIZE];
   logic [pdll_pkg::SLOT_W-1:0]         prev_ram  [pdll_pkg::POOL_SIZE];
   logic signed [pdll_pkg::VALUE_W-1:0] value_ram [pdll_pkg::POOL_SIZE];

   logic                                next_we, prev_we, value_we;
   logic [pdll_pkg::SLOT_W-1:0]         next_waddr, prev_waddr, value_waddr;
   logic [pdll_pkg::SLOT_W-1:0]         next_wdata, prev_wdata;
   logic signed [pdll_pkg::VALUE_W-1:0] value_wdata;
   logic [pdll_pkg::SLOT_W-1:0]         next_rd_ff, prev_rd_ff;
   logic signed [pdll_pkg::VALUE_W-1:0] value_rd_ff;

   // the head sentinel's links live in flops so reset can seed them
   logic [pdll_pkg::SLOT_W-1:0] head_next_ff, head_next_in;
   logic [pdll_pkg::SLOT_W-1:0] head_prev_ff, head_prev_in;

   pdll_pkg::state_type                 state_ff, state_in;
   logic [pdll_pkg::OP_W-1:0]           op_ff;
   logic [pdll_pkg::SLOT_W-1:0]         idx_ff;
   logic signed [pdll_pkg::VALUE_W-1:0] val_ff;
   logic [pdll_pkg::SLOT_W-1:0]         succ_ff, succ_in;
   logic [pdll_pkg::SLOT_W-1:0]         fresh_ff, fresh_in;
   pdll_pkg::rsp_type                   res_ff, res_in;
   pdll_pkg::rsp_type                   rsp_data_ff;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic                         req_take;
   logic                         rsp_load;
   logic [pdll_pkg::SLOT_W-1:0]  node_next, node_prev;
   logic                         idx_used;
   pdll_pkg::used_ctrl_type      used_ctrl;
   pdll_pkg::scan_res_type       scan_res;

   pdll_free_scan u_free_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (used_ctrl),
      .query_slot (idx_ff),
      .query_used (idx_used),
      .scan_res   (scan_res)
   );

   assign req_stall = (state_ff != pdll_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // output register frees up when empty or taken this cycle
   assign rsp_load = (state_ff == pdll_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // slot zero reads from the head flops
   assign node_next = (idx_ff == '0) ? head_next_ff : next_rd_ff;
   assign node_prev = (idx_ff == '0) ? head_prev_ff : prev_rd_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      succ_in     = succ_ff;
      fresh_in    = fresh_ff;
      res_in      = res_ff;
      next_we     = 1'b0;
      next_waddr  = '0;
      next_wdata  = '0;
      prev_we     = 1'b0;
      prev_waddr  = '0;
      prev_wdata  = '0;
      value_we    = 1'b0;
      value_waddr = fresh_ff;
      value_wdata = val_ff;
      used_ctrl   = '0;

      unique case (state_ff)
         pdll_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = pdll_pkg::S_LOOK;
            end
         end

         pdll_pkg::S_LOOK: begin
            // failed steps echo the slot and report no node data
            res_in.slot_used  = idx_ff;
            res_in.read_value = '0;
            res_in.next_index = '0;
            res_in.prev_index = '0;
            res_in.status     = pdll_pkg::STAT_REFUSED;
            state_in          = pdll_pkg::S_DONE;
            unique case (op_ff)
               pdll_pkg::OP_INSERT: begin
                  if (!idx_used) begin
                     res_in.status = pdll_pkg::STAT_UNALLOC;
                  end else begin
                     succ_in         = node_next;
                     used_ctrl.start = 1'b1;
                     state_in        = pdll_pkg::S_SCAN;
                  end
               end
               pdll_pkg::OP_DELETE: begin
                  priority if (!idx_used) begin
                     res_in.status = pdll_pkg::STAT_UNALLOC;
                  end else if ((idx_ff == '0) || (node_next == node_prev)) begin
                     res_in.status = pdll_pkg::STAT_REFUSED;
                  end else begin
                     // unlink: prev.next = next, next.prev = prev
                     next_we          = 1'b1;
                     next_waddr       = node_prev;
                     next_wdata       = node_next;
                     prev_we          = 1'b1;
                     prev_waddr       = node_next;
                     prev_wdata       = node_prev;
                     used_ctrl.clr_en = 1'b1;
                     used_ctrl.slot   = idx_ff;
                     res_in.status    = pdll_pkg::STAT_OK;
                  end
               end
               pdll_pkg::OP_READ: begin
                  if (!idx_used) begin
                     res_in.status = pdll_pkg::STAT_UNALLOC;
                  end else begin
                     res_in.status     = pdll_pkg::STAT_OK;
                     res_in.read_value = (idx_ff == '0) ? '0 : value_rd_ff;
                     res_in.next_index = node_next;
                     res_in.prev_index = node_prev;
                  end
               end
               default: begin
                  res_in.status = pdll_pkg::STAT_REFUSED;
               end
            endcase
         end

         pdll_pkg::S_SCAN: begin
            if (scan_res.done) begin
               if (scan_res.found) begin
                  fresh_in = scan_res.slot;
                  state_in = pdll_pkg::S_LINK_A;
               end else begin
                  res_in.status = pdll_pkg::STAT_FULL;
                  state_in      = pdll_pkg::S_DONE;
               end
            end
         end

         pdll_pkg::S_LINK_A: begin
            // new node: value, next = old successor, prev = anchor
            value_we   = 1'b1;
            next_we    = 1'b1;
            next_waddr = fresh_ff;
            next_wdata = succ_ff;
            prev_we    = 1'b1;
            prev_waddr = fresh_ff;
            prev_wdata = idx_ff;
            state_in   = pdll_pkg::S_LINK_B;
         end

         pdll_pkg::S_LINK_B: begin
            // splice in: successor.prev and anchor.next point to the new node
            next_we          = 1'b1;
            next_waddr       = idx_ff;
            next_wdata       = fresh_ff;
            prev_we          = 1'b1;
            prev_waddr       = succ_ff;
            prev_wdata       = fresh_ff;
            used_ctrl.set_en = 1'b1;
            used_ctrl.slot   = fresh_ff;
            res_in.status    = pdll_pkg::STAT_OK;
            res_in.slot_used = fresh_ff;
            state_in         = pdll_pkg::S_DONE;
         end

         pdll_pkg::S_DONE: begin
            if (rsp_load) begin
               state_in = pdll_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pdll_pkg::S_IDLE;
         end
      endcase
   end

   // head link flops shadow writes to slot zero
   always_comb begin
      head_next_in = head_next_ff;
      head_prev_in = head_prev_ff;
      if (next_we && (next_waddr == '0)) begin
         head_next_in = next_wdata;
      end
      if (prev_we && (prev_waddr == '0)) begin
         head_prev_in = prev_wdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_ram[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_ram[prev_waddr] <= prev_wdata;
      end
      if (value_we) begin
         value_ram[value_waddr] <= value_wdata;
      end
      if (req_take) begin
         next_rd_ff  <= next_ram[req_data.node_index];
         prev_rd_ff  <= prev_ram[req_data.node_index];
         value_rd_ff <= value_ram[req_data.node_index];
      end
   end

   // request capture and working registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_data.operation;
         idx_ff <= req_data.node_index;
         val_ff <= req_data.item_value;
      end
      succ_ff  <= succ_in;
      fresh_ff <= fresh_in;
      res_ff   <= res_in;
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdll_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_next_ff <= '0;
         head_prev_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_next_ff <= head_next_in;
         head_prev_ff <= head_prev_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a result only appears out of the final sequencer step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pdll_pkg::S_DONE))
      else $error("result valid without a finished request");

   // an accepted request always starts with the lookup step
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == pdll_pkg::S_LOOK))
      else $error("accepted request did not start the lookup");

   // the head sentinel is never handed out by the scan
   assert property (@(posedge clock) disable iff (reset)
      (scan_res.done && scan_res.found) |-> (scan_res.slot != '0))
      else $error("free scan returned the head slot");

   // a new node never lands on its anchor or on the old successor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdll_pkg::S_LINK_B) |-> ((fresh_ff != idx_ff) && (fresh_ff != succ_ff)))
      else $error("allocated slot collides with the splice point");
`endif

endmodule
